### rtl/bres_pkg.sv
`timescale 1ns / 1ps

package bres_pkg;

  localparam int ROW_WIDTH_BITS = 13;
  localparam int ADDR_BITS      = 24;
  localparam int COLOR_BITS     = 32;

  localparam logic [ROW_WIDTH_BITS-1:0] ROW_WIDTH_RESET = 13'd640;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_t;

  // step directions and major axis of the line in progress
  typedef struct packed {
    logic x_negative;
    logic y_negative;
    logic x_major;
  } line_dir_t;

endpackage

### rtl/bres_setup.sv
`timescale 1ns / 1ps

module bres_setup
  import bres_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [COORD_BITS-1:0] start_x,
  input  logic [COORD_BITS-1:0] start_y,
  input  logic [COORD_BITS-1:0] end_x,
  input  logic [COORD_BITS-1:0] end_y,
  output logic [COORD_BITS:0]   twice_dx,
  output logic [COORD_BITS:0]   twice_dy,
  output logic [COORD_BITS+2:0] err_init,
  output logic [COORD_BITS-1:0] steps_init,
  output line_dir_t             dir
);

  localparam int EW = COORD_BITS + 3;

  logic [COORD_BITS:0]   dx;
  logic [COORD_BITS:0]   dy;
  logic [COORD_BITS:0]   dx_mag;
  logic [COORD_BITS:0]   dy_mag;
  logic [COORD_BITS-1:0] adx;
  logic [COORD_BITS-1:0] ady;

  assign dx = {1'b0, end_x} - {1'b0, start_x};
  assign dy = {1'b0, end_y} - {1'b0, start_y};

  assign dx_mag = dx[COORD_BITS] ? (~dx + 1'b1) : dx;
  assign dy_mag = dy[COORD_BITS] ? (~dy + 1'b1) : dy;
  assign adx    = dx_mag[COORD_BITS-1:0];
  assign ady    = dy_mag[COORD_BITS-1:0];

  assign dir.x_negative = dx[COORD_BITS];
  assign dir.y_negative = dy[COORD_BITS];
  assign dir.x_major    = adx > ady;

  assign twice_dx = {adx, 1'b0};
  assign twice_dy = {ady, 1'b0};

  always_comb begin
    if (dir.x_major) begin
      err_init   = EW'(twice_dy) - EW'(adx);
      steps_init = adx;
    end else begin
      err_init   = EW'(twice_dx) - EW'(ady);
      steps_init = ady;
    end
  end

endmodule

### rtl/bres_step.sv
`timescale 1ns / 1ps

module bres_step
  import bres_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic [ROW_WIDTH_BITS-1:0] row_width,
  input  logic [COORD_BITS-1:0]     cur_x,
  input  logic [COORD_BITS-1:0]     cur_y,
  input  logic [COORD_BITS+2:0]     err_term,
  input  logic [COORD_BITS:0]       twice_dx,
  input  logic [COORD_BITS:0]       twice_dy,
  input  logic [COORD_BITS-1:0]     steps_left,
  input  line_dir_t                 dir,
  output logic [COORD_BITS-1:0]     x_next,
  output logic [COORD_BITS-1:0]     y_next,
  output logic [COORD_BITS+2:0]     err_next,
  output logic [COORD_BITS-1:0]     steps_next,
  output logic                      last,
  output logic [ADDR_BITS-1:0]      address
);

  localparam int EW   = COORD_BITS + 3;
  localparam int PW   = ROW_WIDTH_BITS + COORD_BITS;
  localparam int SUMW = (PW + 1 > ADDR_BITS) ? PW + 1 : ADDR_BITS;
  localparam logic [COORD_BITS-1:0] CoordOne = COORD_BITS'(1);

  logic                  err_ge;
  logic [COORD_BITS-1:0] x_stepped;
  logic [COORD_BITS-1:0] y_stepped;
  logic [EW-1:0]         tdx;
  logic [EW-1:0]         tdy;
  logic [PW-1:0]         prod;
  logic [SUMW-1:0]       addr_sum;

  assign last   = steps_left == '0;
  assign err_ge = ~err_term[EW-1];
  assign tdx    = EW'(twice_dx);
  assign tdy    = EW'(twice_dy);

  assign x_stepped = dir.x_negative ? cur_x - CoordOne : cur_x + CoordOne;
  assign y_stepped = dir.y_negative ? cur_y - CoordOne : cur_y + CoordOne;

  always_comb begin
    if (dir.x_major) begin
      x_next   = x_stepped;
      y_next   = err_ge ? y_stepped : cur_y;
      err_next = (err_ge ? err_term - tdx : err_term) + tdy;
    end else begin
      y_next   = y_stepped;
      x_next   = err_ge ? x_stepped : cur_x;
      err_next = (err_ge ? err_term - tdy : err_term) + tdx;
    end
  end

  assign steps_next = steps_left - CoordOne;

  assign prod     = {{COORD_BITS{1'b0}}, row_width} * {{ROW_WIDTH_BITS{1'b0}}, cur_y};
  assign addr_sum = SUMW'(prod) + SUMW'(cur_x);
  assign address  = addr_sum[ADDR_BITS-1:0];

endmodule

### rtl/bresenham_line_rasterizer.sv
`timescale 1ns / 1ps

// Bresenham line rasterizer.
// Input channel (in_valid/in_ready): a request with mode = load sets up a new
// line from start/end points and color and gives no pixel; a request with
// mode = step gives the next pixel of the line, or nothing when no line is
// in progress. A load while a line is running drops that line.
// Output channel (out_valid/out_ready): one pixel with x, y, the framebuffer
// address row_width*y+x (mod 2^24), the color and a last-pixel flag.
// A pixel is registered and presented in the cycle after its step request
// is taken. Throughput: one request per cycle while the output is not stalled;
// the state update is a sign test and two adds and the address one 13 x
// COORD_BITS multiply and add. A stalled receiver holds the output register;
// in_ready drops only while it is full and not taken. row_width is written
// through cfg_wr_en/cfg_wr_data, by the user only while no line is running;
// the block does not enforce this. Reset (rst, synchronous) returns
// row_width to 640, clears the line state and empties the output register.
module bresenham_line_rasterizer
  import bres_pkg::*;
#(
  parameter int COORD_BITS = 12
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [ROW_WIDTH_BITS-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      mode,
  input  logic [COORD_BITS-1:0]     start_x,
  input  logic [COORD_BITS-1:0]     start_y,
  input  logic [COORD_BITS-1:0]     end_x,
  input  logic [COORD_BITS-1:0]     end_y,
  input  logic [COLOR_BITS-1:0]     line_color,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COORD_BITS-1:0]     pixel_x,
  output logic [COORD_BITS-1:0]     pixel_y,
  output logic [ADDR_BITS-1:0]      pixel_address,
  output logic [COLOR_BITS-1:0]     pixel_color,
  output logic                      last_pixel
);

  logic [ROW_WIDTH_BITS-1:0] row_width;
  logic [COORD_BITS-1:0]     cur_x;
  logic [COORD_BITS-1:0]     cur_y;
  logic [COORD_BITS+2:0]     err_term;
  logic [COORD_BITS:0]       twice_dx;
  logic [COORD_BITS:0]       twice_dy;
  logic [COORD_BITS-1:0]     steps_left;
  line_dir_t                 dir;
  logic                      busy;
  logic [COLOR_BITS-1:0]     held_color;

  logic [COORD_BITS:0]       setup_tdx;
  logic [COORD_BITS:0]       setup_tdy;
  logic [COORD_BITS+2:0]     setup_err;
  logic [COORD_BITS-1:0]     setup_steps;
  line_dir_t                 setup_dir;

  logic [COORD_BITS-1:0]     x_next;
  logic [COORD_BITS-1:0]     y_next;
  logic [COORD_BITS+2:0]     err_next;
  logic [COORD_BITS-1:0]     steps_next;
  logic                      step_last;
  logic [ADDR_BITS-1:0]      step_addr;

  logic in_fire;
  logic is_load;
  logic emit;

  assign in_ready = ~out_valid | out_ready;
  assign in_fire  = in_valid & in_ready;
  assign is_load  = mode == MODE_LOAD;
  assign emit     = in_fire & (mode == MODE_STEP) & busy;

  bres_setup #(
    .COORD_BITS(COORD_BITS)
  ) u_setup (
    .start_x   (start_x),
    .start_y   (start_y),
    .end_x     (end_x),
    .end_y     (end_y),
    .twice_dx  (setup_tdx),
    .twice_dy  (setup_tdy),
    .err_init  (setup_err),
    .steps_init(setup_steps),
    .dir       (setup_dir)
  );

  bres_step #(
    .COORD_BITS(COORD_BITS)
  ) u_step (
    .row_width (row_width),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .err_term  (err_term),
    .twice_dx  (twice_dx),
    .twice_dy  (twice_dy),
    .steps_left(steps_left),
    .dir       (dir),
    .x_next    (x_next),
    .y_next    (y_next),
    .err_next  (err_next),
    .steps_next(steps_next),
    .last      (step_last),
    .address   (step_addr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      row_width <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x      <= '0;
      cur_y      <= '0;
      err_term   <= '0;
      twice_dx   <= '0;
      twice_dy   <= '0;
      steps_left <= '0;
      dir        <= '0;
      busy       <= 1'b0;
      held_color <= '0;
    end else if (in_fire && is_load) begin
      cur_x      <= start_x;
      cur_y      <= start_y;
      err_term   <= setup_err;
      twice_dx   <= setup_tdx;
      twice_dy   <= setup_tdy;
      steps_left <= setup_steps;
      dir        <= setup_dir;
      busy       <= 1'b1;
      held_color <= line_color;
    end else if (emit) begin
      if (step_last) begin
        busy <= 1'b0;
      end else begin
        cur_x      <= x_next;
        cur_y      <= y_next;
        err_term   <= err_next;
        steps_left <= steps_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= emit;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x       <= cur_x;
      pixel_y       <= cur_y;
      pixel_address <= step_addr;
      pixel_color   <= held_color;
      last_pixel    <= step_last;
    end
  end

  a_load_arms: assert property (@(posedge clk) disable iff (rst)
    in_fire && is_load |=> busy && !out_valid)
    else $error("load request did not arm a line");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    emit && step_last |=> !busy && out_valid && last_pixel)
    else $error("final pixel did not end the line");

  a_idle_tick: assert property (@(posedge clk) disable iff (rst)
    in_fire && !is_load && !busy |=> !busy && !out_valid && $stable(cur_x) && $stable(cur_y))
    else $error("idle step request changed state or gave a pixel");

  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while output register is stalled");

endmodule
